@@ src/mmf_pkg.sv @@
// ----------------------------------------------------------------------------
// mmf_pkg: shared types and constants for the midi message framer
// Message kinds, operation codes, MIDI byte constants and the data-byte
// count lookup for status bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package mmf_pkg;

   // default size of the system exclusive store
   localparam int unsigned EXCLUSIVE_DEPTH_DEF = 4096;

   // fixed field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned DATA_W   = 7;
   localparam int unsigned INDEX_W  = 12;
   localparam int unsigned LENGTH_W = 13;

   // operation codes on the request channel
   localparam logic OP_FEED = 1'b0;
   localparam logic OP_READ = 1'b1;

   // MIDI byte constants
   localparam logic [7:0] MIDI_REALTIME_MIN = 8'hF8;
   localparam logic [7:0] MIDI_SYSEX_START  = 8'hF0;
   localparam logic [7:0] MIDI_SYSEX_END    = 8'hF7;
   localparam logic [7:0] MIDI_TIME_CODE    = 8'hF1;
   localparam logic [7:0] MIDI_SONG_POS     = 8'hF2;
   localparam logic [7:0] MIDI_SONG_SEL     = 8'hF3;
   localparam logic [7:0] MIDI_NONE         = 8'h00;

   // kind of a result item
   typedef enum logic [1:0] {
      KIND_SINGLE = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_SYSEX  = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   // one framed result, as handed from the parser to the output stage
   typedef struct packed {
      logic                valid;
      kind_type            kind;
      logic [BYTE_W-1:0]   status;
      logic [DATA_W-1:0]   first;
      logic [DATA_W-1:0]   second;
      logic [LENGTH_W-1:0] length;
      logic                hit;
   } result_type;

   // number of data bytes that follow a status byte
   function automatic logic [1:0] needed_data(input logic [7:0] s);
      logic [1:0] n;
      n = 2'd0;
      case (s[7:4])
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
         4'hC, 4'hD:                   n = 2'd1;
         4'hF: begin
            if (s == MIDI_TIME_CODE || s == MIDI_SONG_SEL) begin
               n = 2'd1;
            end else if (s == MIDI_SONG_POS) begin
               n = 2'd2;
            end
         end
         default:                      n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

@@ src/mmf_store.sv @@
// ----------------------------------------------------------------------------
// mmf_store: system exclusive byte store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmf_store #(
   parameter int unsigned DEPTH = mmf_pkg::EXCLUSIVE_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [mmf_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [mmf_pkg::BYTE_W-1:0] rd_data
);
   import mmf_pkg::*;

   logic [BYTE_W-1:0] store_mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/mmf_parser.sv @@
// ----------------------------------------------------------------------------
// mmf_parser: MIDI byte framing state machine
// Keeps running status, pending data and sysex progress; issues store
// writes and reads and builds the result of each accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module mmf_parser #(
   parameter int unsigned DEPTH = mmf_pkg::EXCLUSIVE_DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic                        op,
   input  wire logic [mmf_pkg::BYTE_W-1:0]  byte_in,
   input  wire logic [mmf_pkg::INDEX_W-1:0] read_index,
   output mmf_pkg::result_type              result,
   output logic                             wr_en,
   output logic      [$clog2(DEPTH)-1:0]    wr_addr,
   output logic      [mmf_pkg::BYTE_W-1:0]  wr_data,
   output logic                             rd_en,
   output logic      [$clog2(DEPTH)-1:0]    rd_addr
);
   import mmf_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_CNT   = CW'(1);

   // framer state
   logic [7:0]        running_ff, running_in;
   logic [DATA_W-1:0] held_ff, held_in;
   logic [1:0]        count_ff, count_in;
   logic              in_ex_ff, in_ex_in;
   logic [CW-1:0]     ex_count_ff, ex_count_in;

   // widened views for compares and part-selects
   logic [31:0] index_wide;
   logic [31:0] count_wide;
   logic [31:0] len_wide;
   logic [1:0]  need;
   logic        room;
   logic        fresh;

   assign index_wide = 32'(read_index);
   assign count_wide = 32'(ex_count_ff);
   assign len_wide   = 32'(ex_count_ff + ONE_CNT);
   assign need       = needed_data(running_ff);
   assign room       = (ex_count_ff < DEPTH_CNT);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= MIDI_NONE;
         held_ff     <= '0;
         count_ff    <= '0;
         in_ex_ff    <= 1'b0;
         ex_count_ff <= '0;
      end else begin
         running_ff  <= running_in;
         held_ff     <= held_in;
         count_ff    <= count_in;
         in_ex_ff    <= in_ex_in;
         ex_count_ff <= ex_count_in;
      end
   end

   // next state, store access and result
   always_comb begin
      running_in  = running_ff;
      held_in     = held_ff;
      count_in    = count_ff;
      in_ex_in    = in_ex_ff;
      ex_count_in = ex_count_ff;
      wr_en       = 1'b0;
      wr_addr     = count_wide[AW-1:0];
      wr_data     = byte_in;
      rd_en       = 1'b0;
      rd_addr     = index_wide[AW-1:0];
      fresh       = 1'b0;
      result      = '0;
      result.kind = KIND_SINGLE;

      if (accept && op == OP_READ) begin
         // buffer read: data comes from the registered read port of the store
         rd_en         = 1'b1;
         result.valid  = 1'b1;
         result.kind   = KIND_READ;
         result.hit    = (index_wide < count_wide) && (index_wide < 32'(DEPTH));
      end else if (accept) begin
         if (byte_in >= MIDI_REALTIME_MIN) begin
            // realtime passes through untouched
            result.valid  = 1'b1;
            result.status = byte_in;
            result.length = LENGTH_W'(1);
         end else if (in_ex_ff && byte_in == MIDI_SYSEX_END) begin
            // end of sysex
            in_ex_in = 1'b0;
            result.valid  = 1'b1;
            result.kind   = KIND_SYSEX;
            result.status = MIDI_SYSEX_START;
            result.length = count_wide[LENGTH_W-1:0];
            if (room) begin
               wr_en          = 1'b1;
               ex_count_in    = ex_count_ff + ONE_CNT;
               result.length  = len_wide[LENGTH_W-1:0];
            end
         end else if (in_ex_ff && !byte_in[7]) begin
            // sysex payload byte
            if (room) begin
               wr_en       = 1'b1;
               ex_count_in = ex_count_ff + ONE_CNT;
            end
         end else begin
            // any other byte is handled afresh; a status inside sysex abandons it
            in_ex_in = 1'b0;
            fresh    = 1'b1;
         end

         if (fresh) begin
            if (byte_in == MIDI_SYSEX_START) begin
               wr_en       = 1'b1;
               wr_addr     = '0;
               ex_count_in = ONE_CNT;
               in_ex_in    = 1'b1;
            end else if (byte_in[7]) begin
               count_in = 2'd0;
               if (needed_data(byte_in) == 2'd0) begin
                  running_in    = MIDI_NONE;
                  result.valid  = 1'b1;
                  result.status = byte_in;
                  result.length = LENGTH_W'(1);
               end else begin
                  running_in = byte_in;
               end
            end else if (running_ff != MIDI_NONE) begin
               if (3'(count_ff) + 3'd1 < 3'(need)) begin
                  held_in  = byte_in[DATA_W-1:0];
                  count_in = count_ff + 2'd1;
               end else begin
                  count_in      = 2'd0;
                  result.valid  = 1'b1;
                  result.kind   = KIND_DATA;
                  result.status = running_ff;
                  if (need == 2'd2) begin
                     result.first  = held_ff;
                     result.second = byte_in[DATA_W-1:0];
                     result.length = LENGTH_W'(3);
                  end else begin
                     result.first  = byte_in[DATA_W-1:0];
                     result.length = LENGTH_W'(2);
                  end
                  // system common clears running status once complete
                  if (running_ff >= MIDI_SYSEX_START) begin
                     running_in = MIDI_NONE;
                  end
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ src/midi_message_framer_unit.sv @@
// ----------------------------------------------------------------------------
// midi_message_framer_unit: MIDI byte stream framer with sysex store
// Frames raw MIDI bytes into messages with running status, passes realtime
// bytes through, collects system exclusive data and serves store reads.
//
//   channel | direction | transfer carries
//   --------+-----------+-------------------------------------------------
//   req_    | in        | op, byte_in, read_index
//   rsp_    | out       | msg_kind, status_byte, first/second_data,
//           |           | msg_length, read_data
//
// One item per cycle while req_ready is high; a result shows in the cycle after
// its transfer, from the registered read port of the sysex store and the output register.
// Items that produce no result are accepted like any other item.
// req_ready is low only while a result waits and rsp_ready is low.
// Reset clears framing state; the store contents are not cleared and need
// no clearing pass, since only written entries can be read back.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_message_framer_unit #(
   parameter int unsigned EXCLUSIVE_DEPTH = mmf_pkg::EXCLUSIVE_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_op,
   input  wire logic [mmf_pkg::BYTE_W-1:0]   req_byte_in,
   input  wire logic [mmf_pkg::INDEX_W-1:0]  req_read_index,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [1:0]                   rsp_msg_kind,
   output logic      [mmf_pkg::BYTE_W-1:0]   rsp_status_byte,
   output logic      [mmf_pkg::DATA_W-1:0]   rsp_first_data,
   output logic      [mmf_pkg::DATA_W-1:0]   rsp_second_data,
   output logic      [mmf_pkg::LENGTH_W-1:0] rsp_msg_length,
   output logic      [mmf_pkg::BYTE_W-1:0]   rsp_read_data
);
   import mmf_pkg::*;

   localparam int unsigned AW = $clog2(EXCLUSIVE_DEPTH);

   logic              accept;
   result_type        result;
   result_type        out_ff, out_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;

   // input transfer when the output slot is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   mmf_parser #(
      .DEPTH (EXCLUSIVE_DEPTH)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .op         (req_op),
      .byte_in    (req_byte_in),
      .read_index (req_read_index),
      .result     (result),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   mmf_store #(
      .DEPTH (EXCLUSIVE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      if (req_ready) begin
         rsp_valid_in = accept && result.valid;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   // result ports; store data is shown only for an in-range read
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_msg_kind    = out_ff.kind;
   assign rsp_status_byte = out_ff.status;
   assign rsp_first_data  = out_ff.first;
   assign rsp_second_data = out_ff.second;
   assign rsp_msg_length  = out_ff.length;
   assign rsp_read_data   = (out_ff.kind == KIND_READ && out_ff.hit) ? rd_data : '0;

`ifndef SYNTHESIS
   // an accepted read always yields a read result on the next cycle
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_READ)
         |=> (rsp_valid && rsp_msg_kind == KIND_READ))
      else $error("accepted read did not produce a read result");

   // store data never leaks into framed messages
   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_msg_kind != KIND_READ) |-> (rsp_read_data == '0))
      else $error("read data nonzero on a framed message");

   // single byte messages have length one, sysex reports carry the start byte
   a_single_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_msg_kind == KIND_SINGLE) |-> (rsp_msg_length == LENGTH_W'(1)))
      else $error("single byte message with wrong length");

   a_sysex_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_msg_kind == KIND_SYSEX) |-> (rsp_status_byte == MIDI_SYSEX_START))
      else $error("sysex result without start status");
`endif

endmodule

`default_nettype wire

@@ bench/midi_message_framer_checker.sv @@
// ----------------------------------------------------------------------------
// midi_message_framer_checker: framing predictor and result scoreboard
// Watches the req_ and rsp_ channels of the framer. Every accepted request
// transfer is run through a local framer that keeps running status, pending
// data and the sysex store, and any message it frames is queued. Every
// accepted response transfer is compared against the oldest queued message.
// ----------------------------------------------------------------------------
module midi_message_framer_checker #(
   parameter int unsigned DEPTH = mmf_pkg::EXCLUSIVE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_op,
   input  logic [mmf_pkg::BYTE_W-1:0]   req_byte_in,
   input  logic [mmf_pkg::INDEX_W-1:0]  req_read_index,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [1:0]                   rsp_msg_kind,
   input  logic [mmf_pkg::BYTE_W-1:0]   rsp_status_byte,
   input  logic [mmf_pkg::DATA_W-1:0]   rsp_first_data,
   input  logic [mmf_pkg::DATA_W-1:0]   rsp_second_data,
   input  logic [mmf_pkg::LENGTH_W-1:0] rsp_msg_length,
   input  logic [mmf_pkg::BYTE_W-1:0]   rsp_read_data,
   output int unsigned                  fail_count,
   output int unsigned                  pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import mmf_pkg::*;

   localparam int unsigned SHOWN_FAILS = 10;

   // high nibbles of the channel voice status bytes
   localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
   localparam logic [3:0] NIB_POLY_PRESS = 4'hA;
   localparam logic [3:0] NIB_CONTROL    = 4'hB;
   localparam logic [3:0] NIB_PROGRAM    = 4'hC;
   localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
   localparam logic [3:0] NIB_PITCH_BEND = 4'hE;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   status;
      logic [DATA_W-1:0]   first_data;
      logic [DATA_W-1:0]   second_data;
      logic [LENGTH_W-1:0] length;
      logic [BYTE_W-1:0]   rdata;
   } framed_msg_type;

   // local framer state
   logic [BYTE_W-1:0]   run_status;
   logic [DATA_W-1:0]   held_byte;
   logic [1:0]          held_count;
   logic                sysex_open;
   logic [LENGTH_W-1:0] sysex_len;
   logic [BYTE_W-1:0]   sysex_mem [DEPTH];

   framed_msg_type expected_msgs [$];

   // data bytes that complete a message opened by status byte s
   function automatic int unsigned data_bytes_for(input logic [BYTE_W-1:0] s);
      case (s[7:4])
         NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRESS, NIB_CONTROL, NIB_PITCH_BEND:
            return 2;
         NIB_PROGRAM, NIB_CHAN_PRESS:
            return 1;
         default: ;
      endcase
      if (s == MIDI_TIME_CODE || s == MIDI_SONG_SEL) return 1;
      if (s == MIDI_SONG_POS) return 2;
      return 0;
   endfunction

   // advance the local framer by one request; returns 1 when a message is framed
   function automatic logic frame_item(input logic op, input logic [BYTE_W-1:0] b,
                                       input logic [INDEX_W-1:0] idx,
                                       output framed_msg_type m);
      int unsigned need;
      m = '0;

      // store read, zero past the stored length
      if (op == OP_READ) begin
         m.kind = KIND_READ;
         if (idx < sysex_len) m.rdata = sysex_mem[idx];
         return 1'b1;
      end

      // realtime passes straight through
      if (b >= MIDI_REALTIME_MIN) begin
         m.kind   = KIND_SINGLE;
         m.status = b;
         m.length = 1;
         return 1'b1;
      end

      // inside sysex: data and the end marker are stored, any other status aborts
      if (sysex_open) begin
         if (b == MIDI_SYSEX_END || !b[7]) begin
            if (sysex_len < DEPTH) begin
               sysex_mem[sysex_len] = b;
               sysex_len = sysex_len + 1'b1;
            end
            if (b != MIDI_SYSEX_END) return 1'b0;
            sysex_open = 1'b0;
            m.kind     = KIND_SYSEX;
            m.status   = MIDI_SYSEX_START;
            m.length   = sysex_len;
            return 1'b1;
         end
         sysex_open = 1'b0;
      end

      // sysex start leaves running status and pending data alone
      if (b == MIDI_SYSEX_START) begin
         sysex_mem[0] = b;
         sysex_len    = 1;
         sysex_open   = 1'b1;
         return 1'b0;
      end

      // status byte: latch it, or emit it at once when it takes no data
      if (b[7]) begin
         held_count = 2'd0;
         if (data_bytes_for(b) == 0) begin
            run_status = MIDI_NONE;
            m.kind     = KIND_SINGLE;
            m.status   = b;
            m.length   = 1;
            return 1'b1;
         end
         run_status = b;
         return 1'b0;
      end

      // data byte with nothing latched is dropped
      if (run_status == MIDI_NONE) return 1'b0;

      need = data_bytes_for(run_status);
      if (held_count + 1 < need) begin
         held_byte  = b[DATA_W-1:0];
         held_count = held_count + 2'd1;
         return 1'b0;
      end

      m.kind   = KIND_DATA;
      m.status = run_status;
      if (need == 2) begin
         m.first_data  = held_byte;
         m.second_data = b[DATA_W-1:0];
         m.length      = 3;
      end else begin
         m.first_data = b[DATA_W-1:0];
         m.length     = 2;
      end
      held_count = 2'd0;
      // system common messages do not keep running status
      if (run_status >= MIDI_SYSEX_START) run_status = MIDI_NONE;
      return 1'b1;
   endfunction

   task automatic report_fail(input string what, input framed_msg_type want,
                              input framed_msg_type got);
      if (fail_count < SHOWN_FAILS) begin
         $display("[%0t] %s: expected kind=%0d status=%02h d1=%02h d2=%02h len=%0d rd=%02h",
                  $realtime, what, want.kind, want.status, want.first_data,
                  want.second_data, want.length, want.rdata);
         $display("[%0t] %s:      got kind=%0d status=%02h d1=%02h d2=%02h len=%0d rd=%02h",
                  $realtime, what, got.kind, got.status, got.first_data,
                  got.second_data, got.length, got.rdata);
      end
      fail_count++;
   endtask

   // scoreboard: responses first, then the request accepted at the same edge
   always @(posedge clock) begin
      framed_msg_type got_msg;
      framed_msg_type want_msg;
      framed_msg_type new_msg;
      if (reset) begin
         run_status = MIDI_NONE;
         held_byte  = '0;
         held_count = 2'd0;
         sysex_open = 1'b0;
         sysex_len  = '0;
         fail_count = 0;
         expected_msgs.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_msg = '{kind_type'(rsp_msg_kind), rsp_status_byte, rsp_first_data,
                        rsp_second_data, rsp_msg_length, rsp_read_data};
            if (expected_msgs.size() == 0) begin
               report_fail("unexpected transfer", '0, got_msg);
            end else begin
               want_msg = expected_msgs.pop_front();
               if (got_msg !== want_msg) report_fail("mismatch", want_msg, got_msg);
            end
         end
         if (req_valid && req_ready) begin
            if (frame_item(req_op, req_byte_in, req_read_index, new_msg))
               expected_msgs.push_back(new_msg);
         end
      end
      pending <= expected_msgs.size();
   end

endmodule

@@ bench/midi_message_framer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// midi_message_framer_unit_tb: stimulus and verdict for the MIDI framer
// Feeds a directed byte stream, one long sysex with reads across and past
// its stored bytes, and a run of random MIDI traffic and store reads, with
// random gaps on both channels and one long response stall. Checking lives
// in the checker.
// ----------------------------------------------------------------------------
module midi_message_framer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mmf_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1400;
   localparam int unsigned LONG_SYSEX   = 300;
   localparam int unsigned IDLE_PCT     = 28;
   localparam int unsigned QUIET_FROM   = 800;
   localparam int unsigned QUIET_TO     = 1100;
   localparam int unsigned HOLD_AT      = 1300;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned LIMIT_NS     = 2_000_000;

   // status bytes used by the stimulus
   localparam logic [7:0] NOTE_ON          = 8'h90;
   localparam logic [7:0] CONTROL_CHANGE   = 8'hB0;
   localparam logic [7:0] PROGRAM_CHANGE   = 8'hC0;
   localparam logic [7:0] CHANNEL_PRESSURE = 8'hD0;
   localparam logic [7:0] CHANNEL_LOWEST   = 8'h80;
   localparam logic [7:0] UNDEFINED_F4     = 8'hF4;
   localparam logic [7:0] UNDEFINED_F5     = 8'hF5;
   localparam logic [7:0] TUNE_REQUEST     = 8'hF6;
   localparam logic [7:0] SYSTEM_RESET     = 8'hFF;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_op;
   logic [BYTE_W-1:0]   req_byte_in;
   logic [INDEX_W-1:0]  req_read_index;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [1:0]          rsp_msg_kind;
   logic [BYTE_W-1:0]   rsp_status_byte;
   logic [DATA_W-1:0]   rsp_first_data;
   logic [DATA_W-1:0]   rsp_second_data;
   logic [LENGTH_W-1:0] rsp_msg_length;
   logic [BYTE_W-1:0]   rsp_read_data;
   int unsigned         fail_count;
   int unsigned         pending;

   int unsigned items_sent = 0;
   bit          hold_done  = 1'b0;

   always #2 clock = ~clock;

   midi_message_framer_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_byte_in    (req_byte_in),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_msg_kind   (rsp_msg_kind),
      .rsp_status_byte(rsp_status_byte),
      .rsp_first_data (rsp_first_data),
      .rsp_second_data(rsp_second_data),
      .rsp_msg_length (rsp_msg_length),
      .rsp_read_data  (rsp_read_data)
   );

   midi_message_framer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_byte_in    (req_byte_in),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_msg_kind   (rsp_msg_kind),
      .rsp_status_byte(rsp_status_byte),
      .rsp_first_data (rsp_first_data),
      .rsp_second_data(rsp_second_data),
      .rsp_msg_length (rsp_msg_length),
      .rsp_read_data  (rsp_read_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // stretch of traffic with no gaps on either side
   function automatic bit in_quiet_stretch();
      return items_sent >= QUIET_FROM && items_sent < QUIET_TO;
   endfunction

   // one request transfer, with random gaps ahead of it
   task automatic send_item(input logic op, input logic [BYTE_W-1:0] b,
                            input logic [INDEX_W-1:0] idx);
      while (!in_quiet_stretch() && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_byte_in    <= b;
      req_read_index <= idx;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic feed(input logic [BYTE_W-1:0] b);
      send_item(OP_FEED, b, INDEX_W'($urandom));
   endtask

   task automatic read_store(input int unsigned idx);
      send_item(OP_READ, BYTE_W'($urandom), INDEX_W'(idx));
   endtask

   // data bytes, now and then interleaved with a realtime byte
   task automatic feed_data(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(99) < 5)
            feed(BYTE_W'($urandom_range(MIDI_REALTIME_MIN, SYSTEM_RESET)));
         feed(BYTE_W'($urandom_range(127)));
      end
   endtask

   // response side: random stalls, plus one long hold-off
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= in_quiet_stretch() || $urandom_range(99) >= IDLE_PCT;
            @(posedge clock);
         end
      end
   end

   // run limit
   initial begin
      #(LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

   // stimulus
   initial begin
      int unsigned pick;
      int unsigned n;
      int unsigned stop_at;
      logic [7:0]  st;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= OP_FEED;
      req_byte_in    <= '0;
      req_read_index <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed stream
      feed(8'h45);                       // data with no status latched
      feed(NOTE_ON);
      feed(8'h00);
      feed(8'h7F);
      feed(8'h3C);                       // running status
      feed(MIDI_REALTIME_MIN);           // realtime inside a message
      feed(8'h40);
      feed(SYSTEM_RESET);
      feed(PROGRAM_CHANGE | 8'h0F);
      feed(8'h7F);
      feed(MIDI_SONG_POS);
      feed(8'h01);
      feed(8'h02);
      feed(8'h10);                       // dropped, system common cleared status
      feed(TUNE_REQUEST);
      feed(MIDI_SYSEX_END);              // stray end
      feed(MIDI_SYSEX_START);
      feed(8'h7F);
      feed(8'h00);
      feed(MIDI_SYSEX_END);
      read_store(0);
      read_store(3);
      read_store(EXCLUSIVE_DEPTH_DEF - 1);
      feed(MIDI_SYSEX_START);
      feed(8'h01);
      feed(CONTROL_CHANGE | 8'h03);      // status inside sysex aborts it
      feed(8'h07);
      feed(8'h7F);

      // long sysex, then reads across and past its stored bytes
      feed(MIDI_SYSEX_START);
      feed_data(LONG_SYSEX);
      feed(MIDI_SYSEX_END);
      read_store(LONG_SYSEX + 1);        // end marker
      read_store(LONG_SYSEX + 2);        // first entry past the stored bytes
      read_store(LONG_SYSEX / 2);
      read_store(EXCLUSIVE_DEPTH_DEF - 1);
      read_store(0);
      repeat (16) read_store($urandom_range(LONG_SYSEX + 4));

      // random traffic, mostly well-formed messages
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // channel message, possibly continued under running status
            st = CHANNEL_LOWEST + BYTE_W'($urandom_range(6) << 4) + BYTE_W'($urandom_range(15));
            n  = (st[7:4] == PROGRAM_CHANGE[7:4] || st[7:4] == CHANNEL_PRESSURE[7:4]) ? 1 : 2;
            feed(st);
            feed_data(n * (1 + $urandom_range(3)));
         end else if (pick < 40) begin
            // bare data bytes, whatever is latched
            feed_data(1 + $urandom_range(3));
         end else if (pick < 52) begin
            // system common and single status bytes
            case ($urandom_range(6))
               0: begin feed(MIDI_TIME_CODE); feed_data(1); end
               1: begin feed(MIDI_SONG_POS);  feed_data(2); end
               2: begin feed(MIDI_SONG_SEL);  feed_data(1); end
               3: feed(UNDEFINED_F4);
               4: feed(UNDEFINED_F5);
               5: feed(TUNE_REQUEST);
               default: feed(MIDI_SYSEX_END);
            endcase
            if ($urandom_range(99) < 20) feed_data(1);
         end else if (pick < 68) begin
            // sysex, usually closed, sometimes aborted or left open
            feed(MIDI_SYSEX_START);
            n = ($urandom_range(99) < 10) ? $urandom_range(80) : $urandom_range(24);
            feed_data(n);
            pick = $urandom_range(99);
            if (pick < 80)
               feed(MIDI_SYSEX_END);
            else if (pick < 90)
               feed(CHANNEL_LOWEST | BYTE_W'($urandom_range(8'h77)));
         end else if (pick < 82) begin
            // store reads, in range and beyond
            repeat (1 + $urandom_range(3)) begin
               pick = $urandom_range(99);
               if (pick < 60)
                  read_store($urandom_range(31));
               else if (pick < 85)
                  read_store($urandom_range(EXCLUSIVE_DEPTH_DEF - 1));
               else
                  read_store(EXCLUSIVE_DEPTH_DEF - 1 - $urandom_range(7));
            end
         end else if (pick < 94) begin
            feed(BYTE_W'($urandom_range(MIDI_REALTIME_MIN, SYSTEM_RESET)));
         end else begin
            // noise
            send_item(1'($urandom), BYTE_W'($urandom), INDEX_W'($urandom));
         end
      end
      req_valid <= 1'b0;

      // drain
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
